[design/assert_macros.svh]
// Assertion macros shared by the interrupt line controller RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ILC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ILC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ilc_pkg.sv]
// Types, register map constants and helper functions of the interrupt line controller
package ilc_pkg;

  localparam int unsigned MaxLines = 64;

  // Item kinds carried in the func field
  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_TICK  = 2'd2
  } func_e;

  // Register word addresses (byte offset divided by eight)
  localparam logic [6:0] W_MASK    = 7'h04;
  localparam logic [6:0] W_MSI     = 7'h08;
  localparam logic [6:0] W_EDGE    = 7'h0C;
  localparam logic [6:0] W_CLEAR   = 7'h10;
  localparam logic [6:0] W_BNC_LO  = 7'h18;
  localparam logic [6:0] W_BNC_HI  = 7'h1C;
  localparam logic [6:0] W_STATUS  = 7'h74;
  localparam logic [6:0] W_POL     = 7'h7C;

  // Table areas (byte offset divided by 64)
  localparam logic [3:0] AREA_ROUTE  = 4'h4;
  localparam logic [3:0] AREA_VECTOR = 4'h8;

  typedef struct packed {
    logic [1:0]  func;
    logic [9:0]  addr;
    logic        size;
    logic [63:0] wdata;
    logic [63:0] lines;
  } in_item_t;

  typedef struct packed {
    logic [63:0] rdata;
    logic        irq_out;
    logic        pending_valid;
    logic [5:0]  pending_index;
    logic [7:0]  pending_vector;
    logic [7:0]  pending_route;
  } out_item_t;

  // Widen eight byte enables into a 64-bit lane mask
  function automatic logic [63:0] expand_bytes(input logic [7:0] be);
    logic [63:0] m;
    for (int k = 0; k < 8; k++) begin
      m[8*k +: 8] = {8{be[k]}};
    end
    return m;
  endfunction

  // Index of the lowest set bit of a byte, zero when none is set
  function automatic logic [2:0] lowest8(input logic [7:0] v);
    logic [2:0] idx;
    idx = '0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

endpackage

[design/ilc_intf.sv]
// Valid/ready channel interfaces for the interrupt line controller
interface ilc_in_if;
  logic               valid;
  logic               ready;
  ilc_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ilc_out_if;
  logic               valid;
  logic               ready;
  ilc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/interrupt_line_controller_top.sv]
// An item is taken in IDLE, then passes through EXEC (register update and table write),
// PEND (pending search and table read) and DONE (result assembly into the output register);
// DONE waits while the output is held, and no new item is taken until the state is IDLE again.
// Route and vector bytes sit in two 8x64 synchronous memories with registered reads.
// Reset (asynchronous, active low): every line masked, other registers zero,
// table byte valid bits cleared so unwritten bytes read as zero; no clearing pass.
`include "assert_macros.svh"

module interrupt_line_controller_top #(
  parameter int unsigned LINES = 64
) (
  input logic      clk_i,
  input logic      rst_ni,
  ilc_in_if.sink   in_i,
  ilc_out_if.source out_o
);
  import ilc_pkg::*;

  localparam logic [MaxLines-1:0] LineMask =
    (LINES >= MaxLines) ? {MaxLines{1'b1}} : ((64'd1 << LINES) - 64'd1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_PEND = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e      state_q, state_d;
  in_item_t    item_q;
  out_item_t   out_q;
  logic        out_valid_q;

  logic [63:0] mask_q, mask_d;
  logic [63:0] msi_q, msi_d;
  logic [63:0] edge_q, edge_d;
  logic [63:0] pol_q, pol_d;
  logic [63:0] bnc_lo_q, bnc_lo_d;
  logic [63:0] bnc_hi_q, bnc_hi_d;
  logic [63:0] latch_q, latch_d;
  logic [63:0] prev_q, prev_d;
  logic [63:0] rt_vld_q, rt_vld_d;
  logic [63:0] vt_vld_q, vt_vld_d;

  // Table memories: one row holds the bytes of eight lines
  logic [63:0] route_mem  [8];
  logic [63:0] vector_mem [8];

  logic [63:0] rt_bus_q, vt_bus_q, rt_pnd_q, vt_pnd_q;
  logic [7:0]  rt_bus_vld_q, vt_bus_vld_q, rt_pnd_vld_q, vt_pnd_vld_q;
  logic [63:0] rword_q;
  logic        rd_route_q, rd_vec_q, wide_q;
  logic [2:0]  lane_q;
  logic [5:0]  pidx_q;
  logic        pvalid_q;

  logic [6:0]  word;
  logic [2:0]  row, lane;
  logic [7:0]  be, tbl_be;
  logic [63:0] bmask, wd, lines_m, now_lvl, old_lvl;
  logic        is_rd, is_wr, is_tick, area_route, area_vec, rt_we, vt_we;
  logic [63:0] pend, reg_rd_val;
  logic [7:0]  grp_any, grp_bits;
  logic [2:0]  grp, bitpos;
  logic [63:0] bus_word, rdata;
  logic [7:0]  p_vec, p_rt;
  logic        load;

  // Decode the held item
  assign word       = item_q.addr[9:3];
  assign row        = item_q.addr[5:3];
  assign lane       = item_q.addr[2:0];
  assign be         = item_q.size ? 8'hFF : (8'd1 << lane);
  assign bmask      = expand_bytes(be);
  assign wd         = item_q.size ? item_q.wdata : {8{item_q.wdata[7:0]}};
  assign lines_m    = item_q.lines & LineMask;
  assign is_rd      = (state_q == ST_EXEC) && (item_q.func == FUNC_READ);
  assign is_wr      = (state_q == ST_EXEC) && (item_q.func == FUNC_WRITE);
  assign is_tick    = (state_q == ST_EXEC) && (item_q.func == FUNC_TICK);
  assign area_route = (word[6:3] == AREA_ROUTE);
  assign area_vec   = (word[6:3] == AREA_VECTOR);
  assign tbl_be     = be & LineMask[{row, 3'b000} +: 8];
  assign rt_we      = is_wr && area_route;
  assign vt_we      = is_wr && area_vec;
  assign now_lvl    = lines_m ^ pol_q;
  assign old_lvl    = prev_q ^ pol_q;

  // Pending lines from the current register state
  assign pend = (((prev_q ^ pol_q) & ~edge_q) | (latch_q & edge_q)) & ~mask_q & LineMask;

  // Register window read
  always_comb begin
    unique case (word)
      W_MASK:   reg_rd_val = mask_q;
      W_MSI:    reg_rd_val = msi_q;
      W_EDGE:   reg_rd_val = edge_q;
      W_BNC_LO: reg_rd_val = bnc_lo_q;
      W_BNC_HI: reg_rd_val = bnc_hi_q;
      W_POL:    reg_rd_val = pol_q;
      W_STATUS: reg_rd_val = pend;
      default:  reg_rd_val = '0;
    endcase
  end

  // Register updates for writes and sample ticks
  always_comb begin
    mask_d   = mask_q;
    msi_d    = msi_q;
    edge_d   = edge_q;
    pol_d    = pol_q;
    bnc_lo_d = bnc_lo_q;
    bnc_hi_d = bnc_hi_q;
    latch_d  = latch_q;
    prev_d   = prev_q;
    rt_vld_d = rt_vld_q;
    vt_vld_d = vt_vld_q;
    if (is_wr) begin
      unique case (word)
        W_MASK:   mask_d   = ((mask_q & ~bmask) | (wd & bmask)) & LineMask;
        W_MSI:    msi_d    = ((msi_q & ~bmask) | (wd & bmask)) & LineMask;
        W_EDGE:   edge_d   = ((edge_q & ~bmask) | (wd & bmask)) & LineMask;
        W_POL:    pol_d    = ((pol_q & ~bmask) | (wd & bmask)) & LineMask;
        W_BNC_LO: bnc_lo_d = ((bnc_lo_q & ~bmask) | (wd & bmask)) & LineMask;
        W_BNC_HI: bnc_hi_d = ((bnc_hi_q & ~bmask) | (wd & bmask)) & LineMask;
        W_CLEAR:  latch_d  = latch_q & ~(wd & bmask);
        default:  ;
      endcase
    end
    if (rt_we) begin
      rt_vld_d = rt_vld_q | ({56'b0, tbl_be} << {row, 3'b000});
    end
    if (vt_we) begin
      vt_vld_d = vt_vld_q | ({56'b0, tbl_be} << {row, 3'b000});
    end
    if (is_tick) begin
      latch_d = latch_q | (now_lvl & ~old_lvl & edge_q & LineMask);
      prev_d  = lines_m;
    end
  end

  // Lowest pending line: group of eight first, then bit within it
  always_comb begin
    for (int g = 0; g < 8; g++) begin
      grp_any[g] = |pend[8*g +: 8];
    end
  end
  assign grp      = lowest8(grp_any);
  assign grp_bits = pend[{grp, 3'b000} +: 8];
  assign bitpos   = lowest8(grp_bits);

  // Table memories: byte writes, bus row read, pending row read
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 8; k++) begin
      if (rt_we && tbl_be[k]) begin
        route_mem[row][8*k +: 8] <= wd[8*k +: 8];
      end
      if (vt_we && tbl_be[k]) begin
        vector_mem[row][8*k +: 8] <= wd[8*k +: 8];
      end
    end
    if (is_rd) begin
      rt_bus_q     <= route_mem[row];
      vt_bus_q     <= vector_mem[row];
      rt_bus_vld_q <= rt_vld_q[{row, 3'b000} +: 8];
      vt_bus_vld_q <= vt_vld_q[{row, 3'b000} +: 8];
    end
    if (state_q == ST_PEND) begin
      rt_pnd_q     <= route_mem[grp];
      vt_pnd_q     <= vector_mem[grp];
      rt_pnd_vld_q <= rt_vld_q[{grp, 3'b000} +: 8];
      vt_pnd_vld_q <= vt_vld_q[{grp, 3'b000} +: 8];
    end
  end

  // Hold the accepted item and the intermediate read and search results
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q <= in_i.data;
    end
    if (state_q == ST_EXEC) begin
      rword_q    <= is_rd ? reg_rd_val : '0;
      rd_route_q <= is_rd && area_route;
      rd_vec_q   <= is_rd && area_vec;
      wide_q     <= item_q.size;
      lane_q     <= lane;
    end
    if (state_q == ST_PEND) begin
      pidx_q   <= {grp, bitpos};
      pvalid_q <= |grp_any;
    end
    if (load) begin
      out_q.rdata          <= rdata;
      out_q.irq_out        <= pvalid_q;
      out_q.pending_valid  <= pvalid_q;
      out_q.pending_index  <= pvalid_q ? pidx_q : '0;
      out_q.pending_vector <= p_vec;
      out_q.pending_route  <= p_rt;
    end
  end

  // Assemble the result
  always_comb begin
    if (rd_route_q) begin
      bus_word = rt_bus_q & expand_bytes(rt_bus_vld_q);
    end else if (rd_vec_q) begin
      bus_word = vt_bus_q & expand_bytes(vt_bus_vld_q);
    end else begin
      bus_word = rword_q;
    end
  end
  assign rdata = wide_q ? bus_word : {56'b0, bus_word[{lane_q, 3'b000} +: 8]};
  assign p_vec = (pvalid_q && vt_pnd_vld_q[pidx_q[2:0]]) ?
                 vt_pnd_q[{pidx_q[2:0], 3'b000} +: 8] : 8'd0;
  assign p_rt  = (pvalid_q && rt_pnd_vld_q[pidx_q[2:0]]) ?
                 rt_pnd_q[{pidx_q[2:0], 3'b000} +: 8] : 8'd0;

  assign load = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  // Sequence one item through update, search and assembly
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_i.valid) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_PEND;
      ST_PEND: state_d = ST_DONE;
      ST_DONE: if (load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      mask_q      <= LineMask;
      msi_q       <= '0;
      edge_q      <= '0;
      pol_q       <= '0;
      bnc_lo_q    <= '0;
      bnc_hi_q    <= '0;
      latch_q     <= '0;
      prev_q      <= '0;
      rt_vld_q    <= '0;
      vt_vld_q    <= '0;
    end else begin
      state_q  <= state_d;
      mask_q   <= mask_d;
      msi_q    <= msi_d;
      edge_q   <= edge_d;
      pol_q    <= pol_d;
      bnc_lo_q <= bnc_lo_d;
      bnc_hi_q <= bnc_hi_d;
      latch_q  <= latch_d;
      prev_q   <= prev_d;
      rt_vld_q <= rt_vld_d;
      vt_vld_q <= vt_vld_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Checks on sequencing and the pending search
  `ILC_ASSERT_NXT(a_accept_exec, clk_i, rst_ni, in_i.valid && in_i.ready, state_q == ST_EXEC, "accepted beat did not start execution")
  `ILC_ASSERT_NXT(a_state_hold, clk_i, rst_ni, state_q == ST_PEND, $stable(mask_q) && $stable(latch_q) && $stable(prev_q), "state changed during pending search")
  `ILC_ASSERT_IMP(a_pend_hit, clk_i, rst_ni, state_q == ST_DONE && pvalid_q, pend[pidx_q] && ((pend & ((64'd1 << pidx_q) - 64'd1)) == '0), "pending index is not the lowest pending line")
  `ILC_ASSERT_IMP(a_pend_none, clk_i, rst_ni, state_q == ST_DONE && !pvalid_q, pend == '0, "pending line missed")

endmodule
